### src/tcw_pkg.sv
// Shared types and constants of the text console writer.
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int ACT_W      = 2;
    localparam int CHAR_W     = 8;
    localparam int ATTR_W     = 8;
    localparam int INDEX_W    = 11;
    localparam int POS_W      = 11;
    localparam int CELL_W     = CHAR_W + ATTR_W;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 32;
    localparam int IN_PAD_W   = IN_DATA_W - ACT_W - CHAR_W - ATTR_W - INDEX_W;
    localparam int OUT_PAD_W  = OUT_DATA_W - POS_W - CHAR_W - ATTR_W;

    localparam logic [ACT_W-1:0] ACT_PUT   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_NONE  = 2'd3;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
    localparam logic [ATTR_W-1:0] SCROLL_ATTR  = 8'h0F;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [CHAR_W-1:0]  char_code;
        logic [ATTR_W-1:0]  attribute;
        logic [INDEX_W-1:0] cell_index;
    } t_item;

    typedef struct packed {
        logic [POS_W-1:0]  cursor_position;
        logic [CHAR_W-1:0] read_char;
        logic [ATTR_W-1:0] read_attribute;
    } t_result;

endpackage

### src/tcw_cell_ram.sv
// Character cell memory: one write port, one read port with registered data.
`timescale 1ns / 1ps

module tcw_cell_ram #(
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [ADDR_W-1:0]         i_waddr,
    input  logic [tcw_pkg::CELL_W-1:0] i_wdata,
    input  logic                      i_re,
    input  logic [ADDR_W-1:0]         i_raddr,
    output logic [tcw_pkg::CELL_W-1:0] o_rdata
);

    logic [tcw_pkg::CELL_W-1:0] r_mem [DEPTH];
    logic [tcw_pkg::CELL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/tcw_seq.sv
// Cursor and cell-store sequencer: puts, reads, clear, scroll and init sweeps.
`timescale 1ns / 1ps

module tcw_seq #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    parameter int CELLS   = COLUMNS * ROWS,
    parameter int ADDR_W  = $clog2(CELLS)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  tcw_pkg::t_item             i_item,
    output logic                       o_ready,
    output logic                       o_res_valid,
    output tcw_pkg::t_result           o_res,
    input  logic                       i_res_take,
    output logic                       o_we,
    output logic [ADDR_W-1:0]          o_waddr,
    output logic [tcw_pkg::CELL_W-1:0] o_wdata,
    output logic                       o_re,
    output logic [ADDR_W-1:0]          o_raddr,
    input  logic [tcw_pkg::CELL_W-1:0] i_rdata
);

    localparam int COL_W = $clog2(COLUMNS);
    localparam int ROW_W = $clog2(ROWS);

    localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
    localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(CELLS - COLUMNS);
    localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_CLEAR = 3'd3;
    localparam logic [2:0] S_COPY  = 3'd4;
    localparam logic [2:0] S_FILL  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]                   r_state, n_state;
    logic [ADDR_W-1:0]            r_addr, n_addr;
    logic [COL_W-1:0]             r_col, n_col;
    logic [ROW_W-1:0]             r_row, n_row;
    logic [tcw_pkg::ATTR_W-1:0]   r_attr, n_attr;
    logic [tcw_pkg::CHAR_W-1:0]   r_rchar, n_rchar;
    logic [tcw_pkg::ATTR_W-1:0]   r_rattr, n_rattr;
    logic [ADDR_W-1:0]            w_pos;
    logic                         w_newline;
    logic                         w_idx_ok;

    assign w_pos     = ADDR_W'(ADDR_W'(r_row) * ROW_STEP + ADDR_W'(r_col));
    assign w_newline = (i_item.char_code == tcw_pkg::NEWLINE_CODE);
    assign w_idx_ok  = (32'(i_item.cell_index) < CELLS);

    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        n_col   = r_col;
        n_row   = r_row;
        n_attr  = r_attr;
        n_rchar = r_rchar;
        n_rattr = r_rattr;
        o_we    = 1'b0;
        o_waddr = r_addr;
        o_wdata = '0;
        o_re    = 1'b0;
        o_raddr = r_addr;
        case (r_state)
            S_INIT: begin
                o_we = 1'b1;
                if (r_addr == CELL_LAST) begin
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_rchar = '0;
                    n_rattr = '0;
                    n_attr  = i_item.attribute;
                    case (i_item.action)
                        tcw_pkg::ACT_PUT: begin
                            if (!w_newline) begin
                                o_we    = 1'b1;
                                o_waddr = w_pos;
                                o_wdata = {i_item.attribute, i_item.char_code};
                            end
                            if (w_newline || r_col == COL_LAST) begin
                                n_col = '0;
                                if (r_row == ROW_LAST) begin
                                    n_addr  = '0;
                                    n_state = S_COPY;
                                end else begin
                                    n_row   = r_row + 1'b1;
                                    n_state = S_DONE;
                                end
                            end else begin
                                n_col   = r_col + 1'b1;
                                n_state = S_DONE;
                            end
                        end
                        tcw_pkg::ACT_CLEAR: begin
                            n_col   = '0;
                            n_row   = '0;
                            n_addr  = '0;
                            n_state = S_CLEAR;
                        end
                        tcw_pkg::ACT_READ: begin
                            if (w_idx_ok) begin
                                o_re    = 1'b1;
                                o_raddr = ADDR_W'(i_item.cell_index);
                                n_state = S_READ;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_rchar = i_rdata[tcw_pkg::CHAR_W-1:0];
                n_rattr = i_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
                n_state = S_DONE;
            end
            S_CLEAR: begin
                o_we    = 1'b1;
                o_wdata = {r_attr, tcw_pkg::SPACE_CODE};
                if (r_addr == CELL_LAST) begin
                    n_state = S_DONE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_COPY: begin
                // read one row ahead, write back the cell fetched last cycle
                o_re    = (r_addr != COPY_END);
                o_raddr = r_addr + ROW_STEP;
                o_we    = (r_addr != '0);
                o_waddr = r_addr - 1'b1;
                o_wdata = i_rdata;
                if (r_addr == COPY_END) begin
                    n_state = S_FILL;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_FILL: begin
                o_we    = 1'b1;
                o_wdata = {tcw_pkg::SCROLL_ATTR, tcw_pkg::SPACE_CODE};
                if (r_addr == CELL_LAST) begin
                    n_state = S_DONE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_addr  <= '0;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_col   <= n_col;
            r_row   <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        r_attr  <= n_attr;
        r_rchar <= n_rchar;
        r_rattr <= n_rattr;
    end

    assign o_ready                = (r_state == S_IDLE);
    assign o_res_valid            = (r_state == S_DONE);
    assign o_res.cursor_position  = tcw_pkg::POS_W'(w_pos);
    assign o_res.read_char        = r_rchar;
    assign o_res.read_attribute   = r_rattr;

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= COL_LAST)
        else $error("cursor column beyond last column");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= ROW_LAST)
        else $error("cursor row beyond last row");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_we && o_re) |-> (o_waddr != o_raddr))
        else $error("read and write hit the same cell in one cycle");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == S_IDLE))
        else $error("item started while busy");

    a_scroll_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COPY || r_state == S_FILL) |-> (r_row == ROW_LAST && r_col == '0))
        else $error("scroll running with cursor off the last row start");

endmodule

### src/text_console_writer.sv
// Top level of the text console writer: stream ports, result register, cell store.
// Sequence: a put goes from accept to S_DONE, then into the result register; a read
//   passes S_READ first; a scroll adds the S_COPY and S_FILL sweeps, a clear the S_CLEAR sweep.
// Flow: one item at a time; a new item is accepted only once the last result has left S_DONE.
// Reset: synchronous, active low; afterwards an init sweep zeroes the cell store, and no
//   beat is accepted until it ends.
`timescale 1ns / 1ps

module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input beat
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // [1:0] action, [9:2] char_code, [17:10] attribute, [28:18] cell_index
    input  logic [tcw_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // result beat
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [10:0] cursor_position, [18:11] read_char, [26:19] read_attribute
    output logic [tcw_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);

    tcw_pkg::t_item              w_item;
    tcw_pkg::t_result            w_res;
    logic                        w_start;
    logic                        w_seq_ready;
    logic                        w_res_valid;
    logic                        w_res_take;
    logic                        w_we;
    logic [ADDR_W-1:0]           w_waddr;
    logic [tcw_pkg::CELL_W-1:0]  w_wdata;
    logic                        w_re;
    logic [ADDR_W-1:0]           w_raddr;
    logic [tcw_pkg::CELL_W-1:0]  w_rdata;

    logic                          r_m_valid, n_m_valid;
    logic [tcw_pkg::OUT_DATA_W-1:0] r_m_data;

    // Unpack the input beat, lowest field first.
    assign w_item.action     = i_s_axis_tdata[1:0];
    assign w_item.char_code  = i_s_axis_tdata[9:2];
    assign w_item.attribute  = i_s_axis_tdata[17:10];
    assign w_item.cell_index = i_s_axis_tdata[28:18];

    // Accept whenever the sequencer is idle; a waiting result beat sits in
    // its own register and does not hold off the next item.
    assign o_s_axis_tready = w_seq_ready;
    assign w_start         = i_s_axis_tvalid && w_seq_ready;

    // Move a finished result into the output register when it is free or
    // being drained this cycle.
    assign w_res_take = w_res_valid && (!r_m_valid || i_m_axis_tready);

    always_comb begin
        n_m_valid = r_m_valid;
        if (w_res_take) begin
            n_m_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_take) begin
            r_m_data <= {{tcw_pkg::OUT_PAD_W{1'b0}}, w_res.read_attribute,
                         w_res.read_char, w_res.cursor_position};
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

    tcw_seq #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .CELLS   (CELLS),
        .ADDR_W  (ADDR_W)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_item      (w_item),
        .o_ready     (w_seq_ready),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_take  (w_res_take),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_re        (w_re),
        .o_raddr     (w_raddr),
        .i_rdata     (w_rdata)
    );

    tcw_cell_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

endmodule

### sim/text_console_writer_test.sv
// Self-checking stream testbench for the text console writer: puts, scrolls, clears, reads.
`timescale 1ns / 1ps

module text_console_writer_test;

    localparam int COLUMNS      = 80;
    localparam int ROWS         = 25;
    localparam int CELLS        = COLUMNS * ROWS;
    localparam int RANDOM_ITEMS = 1500;
    // a clear or a scroll sweeps the whole store; leave room for one more sweep after the end
    localparam int DRAIN_CYCLES = 2 * CELLS + 64;
    localparam int LONG_HOLD    = 600;
    localparam int MAX_GAP      = 60;

    typedef struct {
        tcw_pkg::t_item item;
        bit             drain;   // hold this beat back until every reply has come
    } t_console_cmd;

    logic                           i_clk   = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           s_valid = 1'b0;
    logic [tcw_pkg::IN_DATA_W-1:0]  s_data  = '0;
    logic                           s_ready;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [tcw_pkg::OUT_DATA_W-1:0] m_data;

    text_console_writer #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(s_ready),
        .i_s_axis_tdata (s_data),
        .o_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (m_data)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow console: cursor and cell grid, updated on every input beat
    // ------------------------------------------------------------------
    int                         cur_col;
    int                         cur_row;
    logic [tcw_pkg::CELL_W-1:0] screen [CELLS];

    t_console_cmd     pending_cmds [$];
    tcw_pkg::t_result replies_due  [$];

    int  n_gen;          // generated beats that the block acts on
    bit  drain_next;
    int  n_accepted;
    int  n_results;
    int  n_errors;
    int  n_put, n_newline, n_scroll, n_clear, n_read, n_read_off, n_unused;
    bit  in_fire;
    bit  calm;
    longint cycles;
    longint limit_cycles = 64'd100_000_000;

    // Move to column 0 of the next row; scroll the grid once past the last row.
    function automatic void console_new_line();
        int i;
        cur_col = 0;
        cur_row++;
        if (cur_row >= ROWS) begin
            for (i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
            for (i = CELLS - COLUMNS; i < CELLS; i++)
                screen[i] = {tcw_pkg::SCROLL_ATTR, tcw_pkg::SPACE_CODE};
            cur_row = ROWS - 1;
            n_scroll++;
        end
    endfunction

    // Apply one command to the shadow console and return the reply it must produce.
    function automatic tcw_pkg::t_result console_step(input tcw_pkg::t_item it);
        tcw_pkg::t_result r;
        int               i;
        r = '0;
        case (it.action)
            tcw_pkg::ACT_PUT: begin
                n_put++;
                if (it.char_code == tcw_pkg::NEWLINE_CODE) begin
                    n_newline++;
                    console_new_line();
                end else begin
                    screen[cur_row * COLUMNS + cur_col] = {it.attribute, it.char_code};
                    cur_col++;
                    if (cur_col >= COLUMNS) console_new_line();
                end
            end
            tcw_pkg::ACT_CLEAR: begin
                n_clear++;
                for (i = 0; i < CELLS; i++) screen[i] = {it.attribute, tcw_pkg::SPACE_CODE};
                cur_col = 0;
                cur_row = 0;
            end
            tcw_pkg::ACT_READ: begin
                n_read++;
                if (it.cell_index < CELLS) begin
                    r.read_char      = screen[it.cell_index][tcw_pkg::CHAR_W-1:0];
                    r.read_attribute = screen[it.cell_index][tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
                end else begin
                    n_read_off++;
                end
            end
            default: n_unused++;
        endcase
        r.cursor_position = tcw_pkg::POS_W'(cur_row * COLUMNS + cur_col);
        return r;
    endfunction

    // Mostly no gap, sometimes a few cycles, rarely a long stretch.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (calm || r < 55) return 0;
        if (r < 85) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(12, 4);
        return $urandom_range(MAX_GAP, 20);
    endfunction

    task automatic push_cmd(input logic [tcw_pkg::ACT_W-1:0] act, input int ch,
                            input int attr, input int idx);
        t_console_cmd c;
        c.item.action     = act;
        c.item.char_code  = tcw_pkg::CHAR_W'(ch);
        c.item.attribute  = tcw_pkg::ATTR_W'(attr);
        c.item.cell_index = tcw_pkg::INDEX_W'(idx);
        c.drain           = drain_next;
        drain_next        = 1'b0;
        pending_cmds.push_back(c);
        if (act != tcw_pkg::ACT_NONE) n_gen++;
    endtask

    // Pick a read address: anywhere including off-grid, the bottom row, or the top row.
    function automatic int pick_index();
        int r;
        r = $urandom_range(9);
        if (r < 6) return $urandom_range(2047);
        if (r < 8) return $urandom_range(CELLS - 1, CELLS - COLUMNS);
        return $urandom_range(COLUMNS - 1);
    endfunction

    // ------------------------------------------------------------------
    // Input side: offer pending commands at the falling edge
    // ------------------------------------------------------------------
    int tx_gap;

    always @(negedge i_clk) begin : sender
        t_console_cmd                  c;
        logic                          nv;
        logic [tcw_pkg::IN_DATA_W-1:0] nd;
        nv = s_valid;
        nd = s_data;
        calm = ((n_accepted / 150) % 5) == 4;
        if (in_fire) nv = 1'b0;
        if (i_rst_n && !nv) begin
            if (tx_gap > 0) begin
                tx_gap--;
            end else if (pending_cmds.size() > 0 &&
                         !(pending_cmds[0].drain && replies_due.size() != 0)) begin
                c  = pending_cmds.pop_front();
                nd = {{tcw_pkg::IN_PAD_W{1'b0}}, c.item.cell_index, c.item.attribute,
                      c.item.char_code, c.item.action};
                nv = 1'b1;
                tx_gap = pick_gap();
            end
        end
        s_valid <= nv;
        s_data  <= nd;
    end

    // ------------------------------------------------------------------
    // Output side: random back-pressure plus scheduled long holds
    // ------------------------------------------------------------------
    int rx_gap;
    int hold_left;
    int next_hold_at = 300;

    always @(negedge i_clk) begin : receiver
        logic nr;
        if (hold_left > 0) begin
            hold_left--;
            nr = 1'b0;
        end else if (n_results >= next_hold_at) begin
            // stall long enough that the block fills and drops its tready
            next_hold_at += 700;
            hold_left = LONG_HOLD;
            nr = 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            nr = 1'b0;
        end else begin
            nr = 1'b1;
            if (!calm && $urandom_range(3) == 0) rx_gap = pick_gap();
        end
        m_ready <= nr;
    end

    // ------------------------------------------------------------------
    // Rising edge: check result beats, then predict for the input beat
    // ------------------------------------------------------------------
    localparam int CH_LO = tcw_pkg::ACT_W;
    localparam int AT_LO = CH_LO + tcw_pkg::CHAR_W;
    localparam int IX_LO = AT_LO + tcw_pkg::ATTR_W;
    localparam int RC_LO = tcw_pkg::POS_W;
    localparam int RA_LO = RC_LO + tcw_pkg::CHAR_W;

    always @(posedge i_clk) begin : monitor
        tcw_pkg::t_item   it;
        tcw_pkg::t_result got;
        tcw_pkg::t_result want;
        in_fire = i_rst_n && s_valid && s_ready;
        if (i_rst_n && m_valid && m_ready) begin
            got.cursor_position = m_data[tcw_pkg::POS_W-1:0];
            got.read_char       = m_data[RA_LO-1:RC_LO];
            got.read_attribute  = m_data[RA_LO+tcw_pkg::ATTR_W-1:RA_LO];
            n_results++;
            if (replies_due.size() == 0) begin
                $error("result beat with no reply pending: tdata %h", m_data);
                n_errors++;
            end else begin
                want = replies_due.pop_front();
                if (got.cursor_position !== want.cursor_position) begin
                    $error("cursor_position mismatch: expected %0d, actual %0d",
                           want.cursor_position, got.cursor_position);
                    n_errors++;
                end
                if (got.read_char !== want.read_char) begin
                    $error("read_char mismatch: expected %0h, actual %0h",
                           want.read_char, got.read_char);
                    n_errors++;
                end
                if (got.read_attribute !== want.read_attribute) begin
                    $error("read_attribute mismatch: expected %0h, actual %0h",
                           want.read_attribute, got.read_attribute);
                    n_errors++;
                end
            end
        end
        if (in_fire) begin
            it.action     = s_data[CH_LO-1:0];
            it.char_code  = s_data[AT_LO-1:CH_LO];
            it.attribute  = s_data[IX_LO-1:AT_LO];
            it.cell_index = s_data[IX_LO+tcw_pkg::INDEX_W-1:IX_LO];
            replies_due.push_back(console_step(it));
            n_accepted++;
        end
    end

    // Watchdog: abort a hung run
    always @(posedge i_clk) begin : watchdog
        cycles++;
        if (cycles > limit_cycles) begin
            $display("timeout after %0d cycles, %0d replies outstanding",
                     cycles, replies_due.size());
            $display("text_console_writer_test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin : stimulus
        int i, n, kind, r;
        cur_col = 0;
        cur_row = 0;
        for (i = 0; i < CELLS; i++) screen[i] = '0;

        // directed: cleared store, grid edges, off-grid reads, unused action, byte extremes
        push_cmd(tcw_pkg::ACT_READ, 0, 0, 0);
        push_cmd(tcw_pkg::ACT_READ, 0, 0, CELLS - 1);
        push_cmd(tcw_pkg::ACT_READ, 255, 255, CELLS);
        push_cmd(tcw_pkg::ACT_READ, 0, 0, 2047);
        push_cmd(tcw_pkg::ACT_NONE, 255, 255, 2047);
        push_cmd(tcw_pkg::ACT_PUT, 0, 0, 0);             // zero byte is an ordinary character
        push_cmd(tcw_pkg::ACT_PUT, 255, 255, 2047);
        push_cmd(tcw_pkg::ACT_READ, 0, 0, 0);
        push_cmd(tcw_pkg::ACT_READ, 0, 0, 1);
        push_cmd(tcw_pkg::ACT_PUT, tcw_pkg::NEWLINE_CODE, 8'hAA, 0); // newline writes no cell
        push_cmd(tcw_pkg::ACT_READ, 0, 0, 2);
        push_cmd(tcw_pkg::ACT_READ, 0, 0, COLUMNS);
        push_cmd(tcw_pkg::ACT_PUT, 8'h41, 8'h07, 0);
        push_cmd(tcw_pkg::ACT_READ, 0, 0, COLUMNS);
        push_cmd(tcw_pkg::ACT_CLEAR, 0, 255, 0);
        push_cmd(tcw_pkg::ACT_READ, 0, 0, 0);
        push_cmd(tcw_pkg::ACT_READ, 0, 0, CELLS - 1);
        push_cmd(tcw_pkg::ACT_PUT, 8'h55, 8'h55, 0);
        push_cmd(tcw_pkg::ACT_CLEAR, 255, 0, 2047);
        push_cmd(tcw_pkg::ACT_READ, 0, 0, 1234);
        push_cmd(tcw_pkg::ACT_NONE, 0, 0, 0);

        // random: segments of well-formed console traffic with some noise
        n_gen = 0;
        drain_next = 1'b1;
        while (n_gen < RANDOM_ITEMS) begin
            kind = $urandom_range(99);
            if ($urandom_range(9) == 0) drain_next = 1'b1;
            if (kind < 52) begin
                // mixed puts and reads
                n = $urandom_range(20, 8);
                for (i = 0; i < n; i++) begin
                    r = $urandom_range(99);
                    if (r < 55)
                        push_cmd(tcw_pkg::ACT_PUT, ($urandom_range(9) == 0)
                                 ? tcw_pkg::NEWLINE_CODE : $urandom_range(255),
                                 $urandom_range(255), $urandom_range(2047));
                    else if (r < 97)
                        push_cmd(tcw_pkg::ACT_READ, $urandom_range(255), $urandom_range(255),
                                 pick_index());
                    else
                        push_cmd(tcw_pkg::ACT_NONE, $urandom_range(255), $urandom_range(255),
                                 $urandom_range(2047));
                end
            end else if (kind < 72) begin
                // a run of text, at times long enough to wrap the line
                n = $urandom_range(90, 20);
                r = $urandom_range(255);
                for (i = 0; i < n; i++)
                    push_cmd(tcw_pkg::ACT_PUT, ($urandom_range(9) == 0) ? $urandom_range(255)
                             : $urandom_range(126, 32),
                             ($urandom_range(3) == 0) ? $urandom_range(255) : r, 0);
                for (i = 0; i < 3; i++) push_cmd(tcw_pkg::ACT_READ, 0, 0, pick_index());
            end else if (kind < 85) begin
                // newline burst: walk the cursor down, scrolling once it passes the last row
                n = $urandom_range(30, 5);
                for (i = 0; i < n; i++) begin
                    if ($urandom_range(7) == 0)
                        push_cmd(tcw_pkg::ACT_PUT, $urandom_range(126, 32),
                                 $urandom_range(255), 0);
                    push_cmd(tcw_pkg::ACT_PUT, tcw_pkg::NEWLINE_CODE, $urandom_range(255),
                             $urandom_range(2047));
                end
                push_cmd(tcw_pkg::ACT_READ, 0, 0, $urandom_range(CELLS - 1, CELLS - COLUMNS));
            end else if (kind < 92) begin
                r = $urandom_range(3);
                push_cmd(tcw_pkg::ACT_CLEAR, $urandom_range(255),
                         (r == 0) ? 0 : (r == 1) ? 255 : $urandom_range(255),
                         $urandom_range(2047));
                n = $urandom_range(5, 2);
                for (i = 0; i < n; i++) push_cmd(tcw_pkg::ACT_READ, 0, 0, pick_index());
            end else begin
                // noise: any action with arbitrary fields
                n = $urandom_range(8, 3);
                for (i = 0; i < n; i++)
                    push_cmd(tcw_pkg::ACT_W'($urandom_range(3)), $urandom_range(255),
                             $urandom_range(255), $urandom_range(2047));
            end
        end

        // generous bound: every beat a full sweep plus the longest stalls on both sides
        limit_cycles = 3 * (longint'(pending_cmds.size()) * (CELLS + 2 * MAX_GAP + 8)
                            + CELLS + 4 * LONG_HOLD + DRAIN_CYCLES);

        // hold reset, then release it at a falling edge
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (!(pending_cmds.size() == 0 && !s_valid && replies_due.size() == 0))
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d beats in %0d cycles: %0d puts (%0d newlines), %0d scrolls,",
                 n_accepted, cycles, n_put, n_newline, n_scroll);
        $display("  %0d clears, %0d reads (%0d off-grid), %0d unused-action beats",
                 n_clear, n_read, n_read_off, n_unused);
        if (n_errors == 0) begin
            $display("text_console_writer_test passed");
        end else begin
            $display("text_console_writer_test failed");
        end
        $finish;
    end

endmodule

### filelist.f
src/tcw_pkg.sv
src/tcw_cell_ram.sv
src/tcw_seq.sv
src/text_console_writer.sv
sim/text_console_writer_test.sv
